// ===== rtl/core/sdk_pkg.sv =====
// Shared types, constants and CORDIC table for the swerve drive kinematics core.
// No dependencies.
package sdk_pkg;

   localparam int TurnCounts = 8191;
   localparam int CordicSteps = 19;
   localparam int AngW = 24;     // angle in 1/256 count, signed
   localparam int VecW = 33;     // wheel vector component, signed Q12 mm/s
   localparam int CorW = 35;     // CORDIC datapath width
   localparam int SqW = 66;      // sum of squares
   localparam int MagW = 33;     // square root result
   localparam int RpmW = 49;     // magnitude * Q8.8 factor
   localparam int SqrtSteps = 33;
   localparam int DivSteps = 16;

   localparam logic signed [AngW-1:0] HalfTurn = AngW'(1048448);
   localparam logic [12:0] ParkA = 13'(TurnCounts * 215 / 360);
   localparam logic [12:0] ParkB = 13'(TurnCounts * 135 / 360);
   localparam logic [12:0] ParkC = 13'(TurnCounts * 45 / 360);
   localparam logic [12:0] ParkD = 13'(TurnCounts * 315 / 360);

   typedef enum logic [2:0] {
      REG_LIMIT_VX   = 3'd0,
      REG_LIMIT_VY   = 3'd1,
      REG_LIMIT_SPIN = 3'd2,
      REG_ARM_SINE   = 3'd3,
      REG_ARM_COSINE = 3'd4,
      REG_SPEED_RPM  = 3'd5,
      REG_SPEED_CAP  = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] spin_rate;
   } req_type;

   typedef struct packed {
      logic [12:0] angle_a;
      logic [12:0] angle_b;
      logic [12:0] angle_c;
      logic [12:0] angle_d;
      logic [15:0] speed_a;
      logic [15:0] speed_b;
      logic [15:0] speed_c;
      logic [15:0] speed_d;
      logic        parked;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [15:0] data;
   } csr_type;

   function automatic logic signed [AngW-1:0] atan_entry(input int i);
      unique case (i)
         0: atan_entry = AngW'(262112);
         1: atan_entry = AngW'(154734);
         2: atan_entry = AngW'(81757);
         3: atan_entry = AngW'(41501);
         4: atan_entry = AngW'(20831);
         5: atan_entry = AngW'(10426);
         6: atan_entry = AngW'(5214);
         7: atan_entry = AngW'(2607);
         8: atan_entry = AngW'(1304);
         9: atan_entry = AngW'(652);
         10: atan_entry = AngW'(326);
         11: atan_entry = AngW'(163);
         12: atan_entry = AngW'(81);
         13: atan_entry = AngW'(41);
         14: atan_entry = AngW'(20);
         15: atan_entry = AngW'(10);
         16: atan_entry = AngW'(5);
         17: atan_entry = AngW'(3);
         18: atan_entry = AngW'(1);
         default: atan_entry = '0;
      endcase
   endfunction

endpackage

// ===== rtl/core/sdk_if.sv =====
// Valid/ready channel interfaces for the kinematics core.
// Depends on sdk_pkg.
interface sdk_req_if import sdk_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sdk_rsp_if import sdk_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sdk_csr_if import sdk_pkg::*; ();
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sdk_wheel.sv =====
// Per-wheel pipeline: CORDIC angle and square-root magnitude times rpm factor.
// Depends on sdk_pkg. All stages advance on en.
module sdk_wheel import sdk_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [VecW-1:0] x_in,
   input  logic signed [VecW-1:0] y_in,
   input  logic [15:0]            rpm_factor,
   output logic [12:0]            angle,
   output logic [RpmW-1:0]        rpm
);

   localparam int Depth = SqrtSteps;

   logic signed [CorW-1:0] cx_ff [CordicSteps+1];
   logic signed [CorW-1:0] cy_ff [CordicSteps+1];
   logic signed [AngW-1:0] cz_ff [CordicSteps+1];
   logic                   zero_ff [Depth+1];
   logic signed [AngW-1:0] z_hold_ff [Depth+1];
   logic [SqW-1:0]         rem_ff [SqrtSteps+1];
   logic [MagW-1:0]        root_ff [SqrtSteps+1];
   logic [12:0]            angle_ff;
   logic [RpmW-1:0]        rpm_ff;
   logic signed [AngW-1:0] z_fin;
   logic signed [AngW-9:0] cnt;
   logic signed [VecW-1:0] ax, ay;

   assign ax = x_in < 0 ? -x_in : x_in;
   assign ay = y_in < 0 ? -y_in : y_in;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_in == 0) && (y_in == 0);
         rem_ff[0]  <= SqW'($unsigned(ax)) * SqW'($unsigned(ax))
                     + SqW'($unsigned(ay)) * SqW'($unsigned(ay));
         root_ff[0] <= '0;
         if (x_in < 0) begin
            cx_ff[0] <= -CorW'(x_in);
            cy_ff[0] <= -CorW'(y_in);
            cz_ff[0] <= (y_in >= 0) ? HalfTurn : -HalfTurn;
         end else begin
            cx_ff[0] <= CorW'(x_in);
            cy_ff[0] <= CorW'(y_in);
            cz_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en) begin
            if (cy_ff[i] >= 0) begin
               cx_ff[i+1] <= cx_ff[i] + (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] - (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] + atan_entry(i);
            end else begin
               cx_ff[i+1] <= cx_ff[i] - (cy_ff[i] >>> i);
               cy_ff[i+1] <= cy_ff[i] + (cx_ff[i] >>> i);
               cz_ff[i+1] <= cz_ff[i] - atan_entry(i);
            end
         end
      end
   end

   // delay the finished angle to line up with the square root
   always_ff @(posedge clock) begin
      if (en) z_hold_ff[CordicSteps+1] <= cz_ff[CordicSteps];
   end
   for (genvar i = CordicSteps + 1; i < Depth; i++) begin : g_zhold
      always_ff @(posedge clock) begin
         if (en) z_hold_ff[i+1] <= z_hold_ff[i];
      end
   end
   for (genvar i = 0; i < Depth; i++) begin : g_zero
      always_ff @(posedge clock) begin
         if (en) zero_ff[i+1] <= zero_ff[i];
      end
   end

   // restoring square root, one result bit per stage
   for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
      localparam int B = SqrtSteps - 1 - i;
      logic [SqW-1:0] trial;
      assign trial = ((SqW'(root_ff[i]) << 1) | (SqW'(1) << B)) << B;
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[i] >= trial) begin
               rem_ff[i+1]  <= rem_ff[i] - trial;
               root_ff[i+1] <= root_ff[i] | (MagW'(1) << B);
            end else begin
               rem_ff[i+1]  <= rem_ff[i];
               root_ff[i+1] <= root_ff[i];
            end
         end
      end
   end

   assign z_fin = z_hold_ff[Depth] + AngW'(128);
   assign cnt = z_fin[AngW-1:8];

   always_ff @(posedge clock) begin
      if (en) begin
         rpm_ff <= zero_ff[Depth] ? '0
                 : RpmW'(root_ff[SqrtSteps]) * RpmW'(rpm_factor);
         if (zero_ff[Depth])
            angle_ff <= '0;
         else if (cnt > (AngW-8)'(TurnCounts))
            angle_ff <= 13'(cnt - (AngW-8)'(TurnCounts));
         else if (cnt < 0)
            angle_ff <= 13'(cnt + (AngW-8)'(TurnCounts));
         else
            angle_ff <= 13'(cnt);
      end
   end

   assign angle = angle_ff;
   assign rpm   = rpm_ff;

endmodule

// ===== rtl/core/swerve_drive_kinematics_core.sv =====
// Four-wheel swerve inverse kinematics, fully pipelined.
// Throughput: one transaction per cycle; the pipeline stalls as a whole when
// the result is not taken. Synchronous active-high reset clears valid bits
// and loads register defaults (speed_to_rpm 256, motor_speed_cap 65535).
module swerve_drive_kinematics_core import sdk_pkg::*; (
   input logic clock,
   input logic reset,
   sdk_req_if.sink   req,
   sdk_rsp_if.source rsp,
   sdk_csr_if.sink   csr
);

   localparam int Lat = 3 + SqrtSteps + 2 + 1 + DivSteps + 2;

   logic [14:0] lim_vx_ff, lim_vy_ff, lim_spin_ff;
   logic [11:0] arm_s_ff, arm_c_ff;
   logic [15:0] rpm_k_ff, cap_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_vx_ff <= '0; lim_vy_ff <= '0; lim_spin_ff <= '0;
         arm_s_ff <= '0; arm_c_ff <= '0;
         rpm_k_ff <= 16'd256; cap_ff <= 16'hFFFF;
      end else if (csr.valid) begin
         unique case (csr.data.index)
            REG_LIMIT_VX:   lim_vx_ff   <= csr.data.data[14:0];
            REG_LIMIT_VY:   lim_vy_ff   <= csr.data.data[14:0];
            REG_LIMIT_SPIN: lim_spin_ff <= csr.data.data[14:0];
            REG_ARM_SINE:   arm_s_ff    <= csr.data.data[11:0];
            REG_ARM_COSINE: arm_c_ff    <= csr.data.data[11:0];
            REG_SPEED_RPM:  rpm_k_ff    <= csr.data.data;
            REG_SPEED_CAP:  cap_ff      <= csr.data.data;
            default: ;
         endcase
      end
   end

   // global stall: pipeline advances when output slot is free or taken
   logic en;
   logic vld_ff [Lat];
   assign en = !vld_ff[Lat-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lat; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < Lat; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   function automatic logic signed [16:0] clampv(input logic signed [15:0] v,
                                                 input logic [14:0] l);
      logic signed [16:0] sl;
      sl = $signed({2'b0, l});
      if (l == 0) clampv = 17'(v);
      else if (17'(v) > sl) clampv = sl;
      else if (17'(v) < -sl) clampv = -sl;
      else clampv = 17'(v);
   endfunction

   // stage 1: park detect and clamp
   logic signed [16:0] cvx_ff, cvy_ff, cw_ff;
   logic               park_ff [Lat-1];
   always_ff @(posedge clock) begin
      if (en) begin
         park_ff[0] <= req.data.vel_x == 0 && req.data.vel_y == 0
                       && req.data.spin_rate == 0;
         cvx_ff <= clampv(req.data.vel_x, lim_vx_ff);
         cvy_ff <= clampv(req.data.vel_y, lim_vy_ff);
         cw_ff  <= clampv(req.data.spin_rate, lim_spin_ff);
      end
   end
   for (genvar i = 1; i < Lat - 1; i++) begin : g_park
      always_ff @(posedge clock) begin
         if (en) park_ff[i] <= park_ff[i-1];
      end
   end

   // stage 2: velocity scaling and spin products
   logic signed [VecW-1:0] vx2_ff, vy2_ff, ws_ff, wc_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         vx2_ff <= VecW'(cvx_ff) <<< 12;
         vy2_ff <= VecW'(cvy_ff) <<< 12;
         ws_ff  <= VecW'(cw_ff * $signed({1'b0, arm_s_ff}));
         wc_ff  <= VecW'(cw_ff * $signed({1'b0, arm_c_ff}));
      end
   end

   // stage 3: wheel vectors
   logic signed [VecW-1:0] wx_ff [4], wy_ff [4];
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff[0] <= vx2_ff - ws_ff; wy_ff[0] <= vy2_ff - wc_ff;
         wx_ff[1] <= vx2_ff - ws_ff; wy_ff[1] <= vy2_ff + wc_ff;
         wx_ff[2] <= vx2_ff + ws_ff; wy_ff[2] <= vy2_ff + wc_ff;
         wx_ff[3] <= vx2_ff + ws_ff; wy_ff[3] <= vy2_ff - wc_ff;
      end
   end

   logic [12:0]     ang [4];
   logic [RpmW-1:0] rpm [4];
   for (genvar k = 0; k < 4; k++) begin : g_wheel
      sdk_wheel u_wheel (
         .clock(clock), .en(en), .x_in(wx_ff[k]), .y_in(wy_ff[k]),
         .rpm_factor(rpm_k_ff), .angle(ang[k]), .rpm(rpm[k])
      );
   end

   // stage: maximum and scaling decision
   localparam int NumW = RpmW + 16;
   logic [RpmW-1:0] m01, m23, mx;
   assign m01 = rpm[0] > rpm[1] ? rpm[0] : rpm[1];
   assign m23 = rpm[2] > rpm[3] ? rpm[2] : rpm[3];
   assign mx  = m01 > m23 ? m01 : m23;

   logic [RpmW-1:0] r_ff [4];
   logic [12:0]     a_ff [4];
   logic [RpmW-1:0] mx_ff;
   logic            scale_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            r_ff[k] <= rpm[k];
            a_ff[k] <= ang[k];
         end
         mx_ff    <= mx;
         scale_ff <= mx > (RpmW'(cap_ff) << 20);
      end
   end

   // stage: numerator products r*cap, rounded shift for the unscaled path
   logic [NumW-1:0] num_ff [DivSteps+1][4];
   logic [15:0]     q_ff [DivSteps+1][4];
   logic [16:0]     plain_ff [DivSteps+1][4];
   logic [12:0]     ad_ff [DivSteps+1][4];
   logic [RpmW-1:0] den_ff [DivSteps+1];
   logic            sc_ff [DivSteps+1];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            num_ff[0][k]   <= NumW'(r_ff[k]) * NumW'(cap_ff);
            q_ff[0][k]     <= '0;
            plain_ff[0][k] <= 17'((r_ff[k] + (RpmW'(1) << 19)) >> 20);
            ad_ff[0][k]    <= a_ff[k];
         end
         den_ff[0] <= mx_ff;
         sc_ff[0]  <= scale_ff;
      end
   end

   // restoring divider: quotient <= cap, so 16 bits; one bit per stage
   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      localparam int B = DivSteps - 1 - i;
      always_ff @(posedge clock) begin
         if (en) begin
            for (int k = 0; k < 4; k++) begin
               if (sc_ff[i] && num_ff[i][k] >= (NumW'(den_ff[i]) << B)) begin
                  num_ff[i+1][k] <= num_ff[i][k] - (NumW'(den_ff[i]) << B);
                  q_ff[i+1][k]   <= q_ff[i][k] | (16'd1 << B);
               end else begin
                  num_ff[i+1][k] <= num_ff[i][k];
                  q_ff[i+1][k]   <= q_ff[i][k];
               end
               plain_ff[i+1][k] <= plain_ff[i][k];
               ad_ff[i+1][k]    <= ad_ff[i][k];
            end
            den_ff[i+1] <= den_ff[i];
            sc_ff[i+1]  <= sc_ff[i];
         end
      end
   end

   // output register
   rsp_type out_ff;
   logic [15:0] spd [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (sc_ff[DivSteps]) spd[k] = q_ff[DivSteps][k];
         else if (plain_ff[DivSteps][k][16]) spd[k] = 16'hFFFF;
         else spd[k] = plain_ff[DivSteps][k][15:0];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         if (park_ff[Lat-2]) begin
            out_ff <= '{ParkA, ParkB, ParkC, ParkD, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1};
         end else begin
            out_ff <= '{ad_ff[DivSteps][0], ad_ff[DivSteps][1], ad_ff[DivSteps][2],
                        ad_ff[DivSteps][3], spd[0], spd[1], spd[2], spd[3], 1'b0};
         end
      end
   end

   assign rsp.valid = vld_ff[Lat-1];
   assign rsp.data  = out_ff;

endmodule

// ===== rtl/core/sdk_checker.sv =====
// Port-level checks for the kinematics core, bound to the top level.
// Depends on sdk_pkg and swerve_drive_kinematics_core.
module sdk_checker import sdk_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction dropped or changed under stall");

   a_park_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.parked |-> rsp_data.speed_a == 0 && rsp_data.speed_b == 0
         && rsp_data.speed_c == 0 && rsp_data.speed_d == 0)
      else $error("parked result with nonzero speed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_angle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.angle_a <= 13'(TurnCounts) && rsp_data.angle_d <= 13'(TurnCounts))
      else $error("angle out of range");

endmodule

bind swerve_drive_kinematics_core sdk_checker u_sdk_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== test/sdk_kinematics_checker.sv =====
`timescale 1ns / 1ps
// Watches the request, result and register channels of the kinematics core,
// works out each expected result and compares. Depends on sdk_pkg and sdk_if.
module sdk_kinematics_checker import sdk_pkg::*; (
   input  logic clock,
   input  logic reset,
   sdk_req_if.sink   req,
   sdk_rsp_if.sink   rsp,
   sdk_csr_if.sink   csr,
   output int        fail_count,
   output int        pending_count
);

   logic [14:0] lim_vx, lim_vy, lim_spin;
   logic [11:0] arm_s, arm_c;
   logic [15:0] rpm_factor, rpm_cap;
   rsp_type     expected_q[$];

   function automatic longint clamp_cmd(longint v, longint lim);
      if (lim == 0) return v;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [12:0] steer_counts(longint x, longint y);
      longint z, c, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(HalfTurn) : -longint'(HalfTurn);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(atan_entry(i));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_entry(i));
         end
      end
      c = (z + 128) >>> 8;
      if (c > TurnCounts) c -= TurnCounts;
      else if (c < 0) c += TurnCounts;
      return c[12:0];
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic rsp_type predict_wheels(req_type cmd);
      rsp_type     o;
      longint      vx, vy, w, ws, wc;
      longint      wx[4], wy[4];
      logic [63:0] rpm[4], top, cap20, s, sq;
      logic [12:0] ang[4];
      o = '0;
      if (cmd.vel_x == 0 && cmd.vel_y == 0 && cmd.spin_rate == 0) begin
         o.angle_a = ParkA; o.angle_b = ParkB; o.angle_c = ParkC; o.angle_d = ParkD;
         o.parked = 1'b1;
         return o;
      end
      vx = clamp_cmd(longint'(cmd.vel_x), lim_vx) * 4096;
      vy = clamp_cmd(longint'(cmd.vel_y), lim_vy) * 4096;
      w  = clamp_cmd(longint'(cmd.spin_rate), lim_spin);
      ws = w * longint'(arm_s);
      wc = w * longint'(arm_c);
      wx[0] = vx - ws; wy[0] = vy - wc;
      wx[1] = vx - ws; wy[1] = vy + wc;
      wx[2] = vx + ws; wy[2] = vy + wc;
      wx[3] = vx + ws; wy[3] = vy - wc;
      top = 0;
      for (int k = 0; k < 4; k++) begin
         sq = 64'(wx[k] * wx[k]) + 64'(wy[k] * wy[k]);
         ang[k] = steer_counts(wx[k], wy[k]);
         rpm[k] = root_floor(sq) * rpm_factor;
         if (rpm[k] > top) top = rpm[k];
      end
      cap20 = 64'(rpm_cap) << 20;
      o.angle_a = ang[0]; o.angle_b = ang[1]; o.angle_c = ang[2]; o.angle_d = ang[3];
      for (int k = 0; k < 4; k++) begin
         if (top > cap20) s = (rpm[k] * rpm_cap) / top;
         else s = (rpm[k] + (64'd1 << 19)) >> 20;
         if (s > 64'hFFFF) s = 64'hFFFF;
         case (k)
            0: o.speed_a = s[15:0];
            1: o.speed_b = s[15:0];
            2: o.speed_c = s[15:0];
            default: o.speed_d = s[15:0];
         endcase
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_r, got;
      if (reset) begin
         lim_vx <= '0; lim_vy <= '0; lim_spin <= '0;
         arm_s <= '0; arm_c <= '0;
         rpm_factor <= 16'd256; rpm_cap <= 16'hFFFF;
         fail_count <= 0;
         pending_count <= 0;
         expected_q.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            case (reg_index_type'(csr.data.index))
               REG_LIMIT_VX:   lim_vx <= csr.data.data[14:0];
               REG_LIMIT_VY:   lim_vy <= csr.data.data[14:0];
               REG_LIMIT_SPIN: lim_spin <= csr.data.data[14:0];
               REG_ARM_SINE:   arm_s <= csr.data.data[11:0];
               REG_ARM_COSINE: arm_c <= csr.data.data[11:0];
               REG_SPEED_RPM:  rpm_factor <= csr.data.data;
               REG_SPEED_CAP:  rpm_cap <= csr.data.data;
               default: ;
            endcase
         end
         if (req.valid && req.ready) expected_q.push_back(predict_wheels(req.data));
         if (rsp.valid && rsp.ready) begin
            got = rsp.data;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_q.size();
      end
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the kinematics core testbench: clock, reset, command and register
// stimulus, result back-pressure and verdict. Depends on sdk_pkg, sdk_if, checker.
module tb_top;
   import sdk_pkg::*;

   logic clock, reset;
   sdk_req_if req ();
   sdk_rsp_if rsp ();
   sdk_csr_if csr ();
   int fail_count, pending_count;
   int send_idle, stall_pct, hold_cycles, idle_count;
   bit hold_start, hold_taken;
   bit done;

   swerve_drive_kinematics_core DUT (.clock(clock), .reset(reset), .req(req.sink),
      .rsp(rsp.source), .csr(csr.sink));

   sdk_kinematics_checker checker_i (.clock(clock), .reset(reset), .req(req.sink),
      .rsp(rsp.sink), .csr(csr.sink), .fail_count(fail_count),
      .pending_count(pending_count));

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // result back-pressure, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_cycles <= 0;
         hold_taken <= 1'b0;
      end else if (hold_start && !hold_taken) begin
         rsp.ready <= 1'b0;
         hold_cycles <= 300;
         hold_taken <= 1'b1;
      end else if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready) || done) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count > 20000) begin
         $display("simulation failed");
         $finish;
      end
   end

   // leaves valid high; set_all drops it after the last write
   task automatic write_reg(reg_index_type idx, logic [15:0] val);
      csr.data <= '{index: idx, data: val};
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
   endtask

   // leaves valid high so that commands can follow back to back
   task automatic send_cmd(logic [15:0] x, logic [15:0] y, logic [15:0] w);
      if ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req.data <= '{vel_x: x, vel_y: y, spin_rate: w};
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_field(int mode);
      case (mode)
         0: return 16'($urandom());
         1: return 16'($urandom_range(400)) - 16'd200;
         2: return 16'(0);
         default: return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
      endcase
   endfunction

   task automatic random_cmds(int n);
      for (int i = 0; i < n; i++)
         send_cmd(rand_field($urandom_range(9) < 6 ? 0 : $urandom_range(3)),
                  rand_field($urandom_range(9) < 6 ? 0 : $urandom_range(3)),
                  rand_field($urandom_range(9) < 6 ? 0 : $urandom_range(3)));
   endtask

   task automatic set_all(int lx, int ly, int ls, int as, int ac, int rf, int cap);
      write_reg(REG_LIMIT_VX, 16'(lx));
      write_reg(REG_LIMIT_VY, 16'(ly));
      write_reg(REG_LIMIT_SPIN, 16'(ls));
      write_reg(REG_ARM_SINE, 16'(as));
      write_reg(REG_ARM_COSINE, 16'(ac));
      write_reg(REG_SPEED_RPM, 16'(rf));
      write_reg(REG_SPEED_CAP, 16'(cap));
      csr.valid <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      done = 0;
      hold_start = 1'b0;
      req.valid = 1'b0; req.data = '0;
      csr.valid = 1'b0; csr.data = '0;
      send_idle = 0; stall_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset registers, park, extremes, wheel vectors cancelling
      send_cmd(0, 0, 0);
      send_cmd(16'h7FFF, 0, 0);
      send_cmd(16'h8000, 0, 0);
      send_cmd(0, 16'h7FFF, 0);
      send_cmd(0, 16'h8000, 16'h8000);
      send_cmd(16'hFFFF, 16'hFFFF, 16'h7FFF);
      drain();
      set_all(100, 200, 300, 250, 400, 300, 1000);
      send_cmd(0, 0, 0);
      send_cmd(16'h7FFF, 16'h8000, 16'h7FFF);
      send_cmd(16'h8000, 16'h7FFF, 16'h8000);
      send_cmd(16'd50, 16'd0, 16'd0);
      send_cmd(16'hFFF0, 16'd5, 16'd4096);
      send_cmd(16'd0, 16'd0, 16'd1);
      // vx cancels spin term: x = 0 on two wheels, y = 0 with vy
      drain();
      set_all(0, 0, 0, 1, 1, 256, 65535);
      send_cmd(16'd1, 16'd1, 16'd4096);
      send_cmd(16'hFFFF, 16'd1, 16'd4096);
      drain();
      set_all(32767, 32767, 32767, 4095, 4095, 65535, 0);
      send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_cmd(16'd1, 16'd0, 16'd0);
      send_cmd(0, 0, 0);
      drain();

      // random phases across settings and idling patterns
      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle = 0; stall_pct = 0; end
            1: begin send_idle = 85; stall_pct = 0; end
            2: begin send_idle = 0; stall_pct = 85; end
            default: begin send_idle = 30; stall_pct = 30; end
         endcase
         write_reg(reg_index_type'(3'd7), 16'($urandom()));
         set_all($urandom_range(3) == 0 ? 0 : $urandom_range(32767),
                 $urandom_range(3) == 0 ? 0 : $urandom_range(32767),
                 $urandom_range(3) == 0 ? 0 : $urandom_range(32767),
                 $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(3) == 0 ? 256 : $urandom_range(65535),
                 $urandom_range(3) == 0 ? 65535 : $urandom_range(65535));
         if (p == 4) hold_start <= 1'b1;
         random_cmds(115);
         drain();
      end

      done = 1;
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== swerve_drive_kinematics_core.f =====
rtl/core/sdk_pkg.sv
rtl/core/sdk_if.sv
rtl/core/sdk_wheel.sv
rtl/core/swerve_drive_kinematics_core.sv
rtl/core/sdk_checker.sv
test/sdk_kinematics_checker.sv
test/tb_top.sv
